// ----- rtl/i2cee_pkg.sv -----
// Package: field widths, register codes, resets and device codes of the I2C EEPROM byte access.
package i2cee_pkg;

	localparam int ADDRESS_BITS_DEF = 18;
	localparam int ADDR_FIELD_W     = 18;
	localparam int BYTE_W           = 8;
	localparam int PHASE_W          = 8;
	localparam int WAIT_W           = 16;
	localparam int CFG_DATA_W       = 16;
	localparam int IN_DATA_W        = 32;
	localparam int OUT_DATA_W       = 16;

	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_WRITE_WAIT  = 1'b1;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 8'd4;
	localparam logic [WAIT_W-1:0]  WRITE_WAIT_RST  = 16'd4000;

	localparam logic [ADDR_FIELD_W-1:0] BANK3_FLOOR = 18'h2FFFF;
	localparam logic [ADDR_FIELD_W-1:0] BANK2_FLOOR = 18'h1FFFF;
	localparam logic [ADDR_FIELD_W-1:0] BANK1_FLOOR = 18'h0FFFF;

	localparam logic [BYTE_W-1:0] DEV_BANK3 = 8'hAA;
	localparam logic [BYTE_W-1:0] DEV_BANK2 = 8'hA2;
	localparam logic [BYTE_W-1:0] DEV_BANK1 = 8'hA8;
	localparam logic [BYTE_W-1:0] DEV_BANK0 = 8'hA0;

	function automatic logic [BYTE_W-1:0] device_code(input logic [ADDR_FIELD_W-1:0] addr);
		logic [BYTE_W-1:0] code;
		if (addr > BANK3_FLOOR) code = DEV_BANK3;
		else if (addr > BANK2_FLOOR) code = DEV_BANK2;
		else if (addr > BANK1_FLOOR) code = DEV_BANK1;
		else code = DEV_BANK0;
		return code;
	endfunction

endpackage

// ----- rtl/i2c_eeprom_byte_access.sv -----
// Top level: I2C master for one-byte EEPROM writes and random reads, driven by a tick stream.
//
// Every request on the slave stream is one clock tick of the bus sequencer. tuser carries
// the mode (tick, start byte write, start byte read); tdata carries address, write data
// and the sampled SDA level. A start request is taken only while the sequencer is idle;
// otherwise it counts as a plain tick.
// Each accepted request yields exactly one result on the master stream: the SCL and SDA
// levels, SDA drive enable, write protect, busy, a done pulse, the read byte and the
// missing-ack flag, all as they stand after that tick.
// A result is in the output register in the cycle after its request is accepted;
// throughput is one request per cycle while the receiver does not stall, set by the single
// next-state pass between the sequencer registers and the output register. When the
// receiver stalls with a result held, s_tready drops in that cycle and the sequencer holds;
// it advances again in the cycle the held result is taken. Reset (arst_n low) returns the
// sequencer to idle, clears its counters and the held request, empties the output register
// and loads phase_ticks = 4, write_wait_ticks = 4000. The user writes configuration through
// cfg_we / cfg_index / cfg_wdata only while the block is idle; the block does not enforce it.
module i2c_eeprom_byte_access #(
	parameter int ADDRESS_BITS = i2cee_pkg::ADDRESS_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// address[17:0], write_data[25:18], sda_in[26], zero fill [31:27]
	input  logic [i2cee_pkg::IN_DATA_W-1:0]     s_tdata,
	// mode[1:0]
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// scl[0], sda_out[1], sda_drive[2], write_protect[3], busy_res[4], done_res[5],
	// read_byte[13:6], ack_missing[14], zero fill [15]
	output logic [i2cee_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int AW = i2cee_pkg::ADDR_FIELD_W;
	localparam int BW = i2cee_pkg::BYTE_W;
	localparam int PW = i2cee_pkg::PHASE_W;
	localparam int WW = i2cee_pkg::WAIT_W;

	typedef enum logic [4:0] {
		ST_IDLE       = 5'd0,
		ST_START_SET  = 5'd1,
		ST_START_HOLD = 5'd2,
		ST_DEVW_LO    = 5'd4,
		ST_DEVW_HI    = 5'd5,
		ST_AH_LO      = 5'd6,
		ST_AH_HI      = 5'd7,
		ST_AL_LO      = 5'd8,
		ST_AL_HI      = 5'd9,
		ST_DATA_LO    = 5'd10,
		ST_DATA_HI    = 5'd11,
		ST_DEVR_LO    = 5'd12,
		ST_DEVR_HI    = 5'd13,
		ST_RD_LO      = 5'd14,
		ST_RD_HI      = 5'd15,
		ST_RS_LO      = 5'd16,
		ST_RS_SET     = 5'd17,
		ST_RS_HOLD    = 5'd18,
		ST_STOP_LO    = 5'd19,
		ST_STOP_HI    = 5'd20,
		ST_STOP_SET   = 5'd21,
		ST_WAIT       = 5'd22
	} step_t;

	logic [PW-1:0] phase_ticks_q;
	logic [WW-1:0] write_wait_q;

	step_t                   step_q, step_n;
	logic [3:0]              bit_q, bit_n;
	logic [PW-1:0]           pc_q, pc_n;
	logic [BW-1:0]           shift_q, shift_n;
	logic [WW-1:0]           wc_q, wc_n;
	logic [ADDRESS_BITS-1:0] held_q, held_n;
	logic                    rd_q, rd_n;
	logic                    nack_q, nack_n;
	logic                    done_n;

	logic                    m_tvalid_q;
	logic [i2cee_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic [1:0]    in_mode;
	logic [AW-1:0] in_addr;
	logic [BW-1:0] in_wdata;
	logic          in_sda;
	logic          in_acc;

	logic [PW:0]   pc_inc;
	logic [PW-1:0] plen;
	logic          pend;
	logic          byte_step;

	logic [AW-1:0] held_ext;
	logic [BW-1:0] dev;
	logic [BW-1:0] send_val;
	logic [2:0]    bit_sel;
	logic          scl_n, sdo_n, drv_n;
	logic          byte_n;
	logic [i2cee_pkg::OUT_DATA_W-1:0] res_n;

	assign in_mode  = s_tuser;
	assign in_addr  = s_tdata[AW-1:0];
	assign in_wdata = s_tdata[AW+BW-1:AW];
	assign in_sda   = s_tdata[AW+BW];

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// next sequencer state for one tick or request
	always_comb begin
		step_n  = step_q;
		bit_n   = bit_q;
		pc_n    = pc_q;
		shift_n = shift_q;
		wc_n    = wc_q;
		held_n  = held_q;
		rd_n    = rd_q;
		nack_n  = nack_q;
		done_n  = 1'b0;

		pc_inc    = {1'b0, pc_q} + {{PW{1'b0}}, 1'b1};
		plen      = (phase_ticks_q == '0) ? PW'(1) : phase_ticks_q;
		pend      = pc_inc >= {1'b0, plen};
		byte_step = (step_q >= ST_DEVW_LO) && (step_q <= ST_RD_HI);

		if (step_q == ST_IDLE &&
		    (in_mode == i2cee_pkg::MODE_WRITE || in_mode == i2cee_pkg::MODE_READ)) begin
			held_n  = in_addr[ADDRESS_BITS-1:0];
			rd_n    = (in_mode == i2cee_pkg::MODE_READ);
			shift_n = (in_mode == i2cee_pkg::MODE_READ) ? '0 : in_wdata;
			nack_n  = 1'b0;
			bit_n   = '0;
			pc_n    = '0;
			wc_n    = '0;
			step_n  = ST_START_SET;
		end else begin
			case (step_q)
				ST_IDLE: begin
					step_n = ST_IDLE;
				end
				ST_WAIT: begin
					if (wc_q == '0) begin
						step_n = ST_IDLE;
						done_n = 1'b1;
					end else begin
						wc_n = wc_q - WW'(1);
					end
				end
				ST_START_SET, ST_START_HOLD, ST_DEVW_LO, ST_DEVW_HI, ST_AH_LO, ST_AH_HI,
				ST_AL_LO, ST_AL_HI, ST_DATA_LO, ST_DATA_HI, ST_DEVR_LO, ST_DEVR_HI,
				ST_RD_LO, ST_RD_HI, ST_RS_LO, ST_RS_SET, ST_RS_HOLD, ST_STOP_LO,
				ST_STOP_HI, ST_STOP_SET: begin
					pc_n = pend ? '0 : pc_inc[PW-1:0];
					if (pend && byte_step) begin
						if (!step_q[0]) begin
							step_n = step_t'(step_q + 5'd1);
						end else if (bit_q >= 4'd8) begin
							if (step_q != ST_RD_HI && in_sda) nack_n = 1'b1;
							bit_n = '0;
							case (step_q)
								ST_DEVW_HI: step_n = ST_AH_LO;
								ST_AH_HI:   step_n = ST_AL_LO;
								ST_AL_HI:   step_n = rd_q ? ST_RS_LO : ST_DATA_LO;
								ST_DEVR_HI: step_n = ST_RD_LO;
								default:    step_n = ST_STOP_LO;
							endcase
						end else begin
							if (step_q == ST_RD_HI) shift_n = {shift_q[BW-2:0], in_sda};
							bit_n  = bit_q + 4'd1;
							step_n = step_t'(step_q - 5'd1);
						end
					end else if (pend) begin
						case (step_q)
							ST_START_SET:  step_n = ST_START_HOLD;
							ST_START_HOLD: step_n = ST_DEVW_LO;
							ST_RS_LO:      step_n = ST_RS_SET;
							ST_RS_SET:     step_n = ST_RS_HOLD;
							ST_RS_HOLD:    step_n = ST_DEVR_LO;
							ST_STOP_LO:    step_n = ST_STOP_HI;
							ST_STOP_HI:    step_n = ST_STOP_SET;
							default: begin
								if (rd_q) begin
									step_n = ST_IDLE;
									done_n = 1'b1;
								end else begin
									step_n = ST_WAIT;
									wc_n   = write_wait_q;
								end
							end
						endcase
					end
				end
				default: begin
					step_n = ST_IDLE;
				end
			endcase
		end
	end

	// bus levels and result word for the state after this tick
	always_comb begin
		held_ext = AW'(held_n);
		dev      = i2cee_pkg::device_code(held_ext);
		byte_n   = (step_n >= ST_DEVW_LO) && (step_n <= ST_RD_HI);
		bit_sel  = 3'd7 - bit_n[2:0];
		case (step_n)
			ST_DEVW_LO, ST_DEVW_HI: send_val = dev;
			ST_AH_LO, ST_AH_HI:     send_val = held_ext[2*BW-1:BW];
			ST_AL_LO, ST_AL_HI:     send_val = held_ext[BW-1:0];
			ST_DATA_LO, ST_DATA_HI: send_val = shift_n;
			default:                send_val = dev | BW'(1);
		endcase

		scl_n = 1'b1;
		sdo_n = 1'b1;
		drv_n = 1'b0;
		if (byte_n) begin
			scl_n = step_n[0];
			if (step_n == ST_RD_LO || step_n == ST_RD_HI) begin
				if (bit_n >= 4'd8) drv_n = 1'b1;
			end else if (bit_n < 4'd8) begin
				drv_n = 1'b1;
				sdo_n = send_val[bit_sel];
			end
		end else begin
			case (step_n)
				ST_START_SET, ST_RS_SET, ST_STOP_SET: begin
					drv_n = 1'b1;
				end
				ST_START_HOLD, ST_RS_HOLD, ST_STOP_HI: begin
					drv_n = 1'b1;
					sdo_n = 1'b0;
				end
				ST_RS_LO: begin
					scl_n = 1'b0;
					drv_n = 1'b1;
				end
				ST_STOP_LO: begin
					scl_n = 1'b0;
					drv_n = 1'b1;
					sdo_n = 1'b0;
				end
				default: begin
					drv_n = 1'b0;
				end
			endcase
		end

		res_n = {1'b0, nack_n, ((done_n && rd_n) ? shift_n : {BW{1'b0}}), done_n,
		         (step_n != ST_IDLE), !(step_n != ST_IDLE && !rd_n), drv_n, sdo_n, scl_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cee_pkg::PHASE_TICKS_RST;
			write_wait_q  <= i2cee_pkg::WRITE_WAIT_RST;
			step_q        <= ST_IDLE;
			bit_q         <= '0;
			pc_q          <= '0;
			shift_q       <= '0;
			wc_q          <= '0;
			held_q        <= '0;
			rd_q          <= 1'b0;
			nack_q        <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == i2cee_pkg::CFG_PHASE_TICKS) begin
					phase_ticks_q <= cfg_wdata[PW-1:0];
				end else begin
					write_wait_q <= cfg_wdata[WW-1:0];
				end
			end
			if (in_acc) begin
				step_q  <= step_n;
				bit_q   <= bit_n;
				pc_q    <= pc_n;
				shift_q <= shift_n;
				wc_q    <= wc_n;
				held_q  <= held_n;
				rd_q    <= rd_n;
				nack_q  <= nack_n;
			end
			if (in_acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) m_tdata_q <= res_n;
	end

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[5] |-> !m_tdata_q[4])
		else $error("done result still shows busy");

	a_read_byte_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tdata_q[5] |-> m_tdata_q[13:6] == '0)
		else $error("read byte shown without done");

	a_unprotect_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tdata_q[3] |-> m_tdata_q[4])
		else $error("write protect released while idle");

	a_step_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(step_q) && $stable(pc_q))
		else $error("sequencer advanced without an accepted request");

endmodule

// ----- verif/i2cee_checker.sv -----
// Checker for the I2C EEPROM byte access: tracks requests, predicts bus levels, compares results.
module i2cee_checker #(
	parameter int ADDR_BITS = i2cee_pkg::ADDRESS_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [i2cee_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [i2cee_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                               errors,
	output int                               pending
);

	localparam int AW = i2cee_pkg::ADDR_FIELD_W;
	localparam int BW = i2cee_pkg::BYTE_W;
	localparam int PW = i2cee_pkg::PHASE_W;
	localparam int WW = i2cee_pkg::WAIT_W;

	localparam logic [AW-1:0] ADDR_MASK = (18'h1 << ADDR_BITS) - 18'h1;

	typedef enum logic [4:0] {
		SEQ_IDLE       = 5'd0,
		SEQ_START_SET  = 5'd1,
		SEQ_START_HOLD = 5'd2,
		SEQ_DEVW_LO    = 5'd4,
		SEQ_DEVW_HI    = 5'd5,
		SEQ_AH_LO      = 5'd6,
		SEQ_AH_HI      = 5'd7,
		SEQ_AL_LO      = 5'd8,
		SEQ_AL_HI      = 5'd9,
		SEQ_DATA_LO    = 5'd10,
		SEQ_DATA_HI    = 5'd11,
		SEQ_DEVR_LO    = 5'd12,
		SEQ_DEVR_HI    = 5'd13,
		SEQ_RD_LO      = 5'd14,
		SEQ_RD_HI      = 5'd15,
		SEQ_RS_LO      = 5'd16,
		SEQ_RS_SET     = 5'd17,
		SEQ_RS_HOLD    = 5'd18,
		SEQ_STOP_LO    = 5'd19,
		SEQ_STOP_HI    = 5'd20,
		SEQ_STOP_SET   = 5'd21,
		SEQ_WAIT       = 5'd22
	} seq_e;

	// scl in the lowest bit, ack_missing at the top
	typedef struct packed {
		logic          ack_missing;
		logic [BW-1:0] read_byte;
		logic          done;
		logic          busy;
		logic          wp;
		logic          sda_drive;
		logic          sda_out;
		logic          scl;
	} bus_view_t;

	seq_e          step;
	logic [3:0]    bit_idx;
	logic [PW-1:0] phase_cnt;
	logic [BW-1:0] shreg;
	logic [WW-1:0] wait_cnt;
	logic [AW-1:0] addr_q;
	logic          rd_q;
	logic          nack_q;
	logic [PW-1:0] cfg_phase;
	logic [WW-1:0] cfg_wait;
	bus_view_t     bus_q[$];
	int            fail_cnt;

	function automatic logic [BW-1:0] bank_device();
		if (addr_q > i2cee_pkg::BANK3_FLOOR) return i2cee_pkg::DEV_BANK3;
		if (addr_q > i2cee_pkg::BANK2_FLOOR) return i2cee_pkg::DEV_BANK2;
		if (addr_q > i2cee_pkg::BANK1_FLOOR) return i2cee_pkg::DEV_BANK1;
		return i2cee_pkg::DEV_BANK0;
	endfunction

	function automatic logic in_byte(seq_e s);
		return s >= SEQ_DEVW_LO && s <= SEQ_RD_HI;
	endfunction

	function automatic bus_view_t advance_bus(logic [1:0] mode, logic [AW-1:0] addr,
			logic [BW-1:0] wd, logic sda);
		bus_view_t     v;
		logic          done;
		logic [8:0]    plen;
		logic [BW-1:0] byte_out;
		seq_e          lo;
		done = 1'b0;
		if (step == SEQ_IDLE &&
		    (mode == i2cee_pkg::MODE_WRITE || mode == i2cee_pkg::MODE_READ)) begin
			addr_q    = addr & ADDR_MASK;
			rd_q      = (mode == i2cee_pkg::MODE_READ);
			shreg     = rd_q ? '0 : wd;
			nack_q    = 1'b0;
			bit_idx   = '0;
			phase_cnt = '0;
			wait_cnt  = '0;
			step      = SEQ_START_SET;
		end else if (step == SEQ_WAIT) begin
			if (wait_cnt == '0) begin
				step = SEQ_IDLE;
				done = 1'b1;
			end else begin
				wait_cnt = wait_cnt - WW'(1);
			end
		end else if (step != SEQ_IDLE) begin
			plen = (cfg_phase == '0) ? 9'd1 : {1'b0, cfg_phase};
			if ({1'b0, phase_cnt} + 9'd1 < plen) begin
				phase_cnt = phase_cnt + PW'(1);
			end else begin
				phase_cnt = '0;
				if (in_byte(step)) begin
					lo = seq_e'({step[4:1], 1'b0});
					if (!step[0]) begin
						step = seq_e'(step + 5'd1);
					end else if (bit_idx >= 4'd8) begin
						if (step != SEQ_RD_HI && sda) nack_q = 1'b1;
						bit_idx = '0;
						case (lo)
							SEQ_DEVW_LO: step = SEQ_AH_LO;
							SEQ_AH_LO:   step = SEQ_AL_LO;
							SEQ_AL_LO:   step = rd_q ? SEQ_RS_LO : SEQ_DATA_LO;
							SEQ_DEVR_LO: step = SEQ_RD_LO;
							default:     step = SEQ_STOP_LO;
						endcase
					end else begin
						if (step == SEQ_RD_HI) shreg = {shreg[BW-2:0], sda};
						bit_idx = bit_idx + 4'd1;
						step    = seq_e'(step - 5'd1);
					end
				end else begin
					case (step)
						SEQ_START_SET:  step = SEQ_START_HOLD;
						SEQ_START_HOLD: step = SEQ_DEVW_LO;
						SEQ_RS_LO:      step = SEQ_RS_SET;
						SEQ_RS_SET:     step = SEQ_RS_HOLD;
						SEQ_RS_HOLD:    step = SEQ_DEVR_LO;
						SEQ_STOP_LO:    step = SEQ_STOP_HI;
						SEQ_STOP_HI:    step = SEQ_STOP_SET;
						default: begin
							if (rd_q) begin
								step = SEQ_IDLE;
								done = 1'b1;
							end else begin
								step     = SEQ_WAIT;
								wait_cnt = cfg_wait;
							end
						end
					endcase
				end
			end
		end

		v           = '0;
		v.scl       = 1'b1;
		v.sda_out   = 1'b1;
		v.sda_drive = 1'b0;
		if (in_byte(step)) begin
			lo    = seq_e'({step[4:1], 1'b0});
			v.scl = step[0];
			if (lo == SEQ_RD_LO) begin
				// NACK after the read byte
				if (bit_idx >= 4'd8) v.sda_drive = 1'b1;
			end else if (bit_idx < 4'd8) begin
				case (lo)
					SEQ_DEVW_LO: byte_out = bank_device();
					SEQ_AH_LO:   byte_out = addr_q[15:8];
					SEQ_AL_LO:   byte_out = addr_q[7:0];
					SEQ_DATA_LO: byte_out = shreg;
					default:     byte_out = bank_device() | 8'h01;
				endcase
				v.sda_drive = 1'b1;
				v.sda_out   = byte_out[3'd7 - bit_idx[2:0]];
			end
		end else begin
			case (step)
				SEQ_START_SET, SEQ_RS_SET, SEQ_STOP_SET:
					v.sda_drive = 1'b1;
				SEQ_START_HOLD, SEQ_RS_HOLD, SEQ_STOP_HI: begin
					v.sda_drive = 1'b1;
					v.sda_out   = 1'b0;
				end
				SEQ_RS_LO: begin
					v.scl       = 1'b0;
					v.sda_drive = 1'b1;
				end
				SEQ_STOP_LO: begin
					v.scl       = 1'b0;
					v.sda_drive = 1'b1;
					v.sda_out   = 1'b0;
				end
				default: ;
			endcase
		end
		v.wp          = !(step != SEQ_IDLE && !rd_q);
		v.busy        = (step != SEQ_IDLE);
		v.done        = done;
		v.read_byte   = (done && rd_q) ? shreg : '0;
		v.ack_missing = nack_q;
		return v;
	endfunction

	function automatic void check_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_val, got_val);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_view_t exp_v;
		bus_view_t got_v;
		if (!arst_n) begin
			step      = SEQ_IDLE;
			bit_idx   = '0;
			phase_cnt = '0;
			shreg     = '0;
			wait_cnt  = '0;
			addr_q    = '0;
			rd_q      = 1'b0;
			nack_q    = 1'b0;
			cfg_phase = i2cee_pkg::PHASE_TICKS_RST;
			cfg_wait  = i2cee_pkg::WRITE_WAIT_RST;
			bus_q.delete();
			fail_cnt  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					i2cee_pkg::CFG_PHASE_TICKS: cfg_phase = cfg_wdata[PW-1:0];
					i2cee_pkg::CFG_WRITE_WAIT:  cfg_wait  = cfg_wdata[WW-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_v = bus_view_t'(m_tdata[$bits(bus_view_t)-1:0]);
				if (bus_q.size() == 0) begin
					$display("%0t unexpected result: expected none actual %0h", $time, m_tdata);
					fail_cnt++;
				end else if (^m_tdata === 1'bx) begin
					exp_v = bus_q.pop_front();
					$display("%0t unknown result: expected %0h actual %0h", $time, exp_v, m_tdata);
					fail_cnt++;
				end else begin
					exp_v = bus_q.pop_front();
					check_field("scl", int'(exp_v.scl), int'(got_v.scl));
					check_field("sda_out", int'(exp_v.sda_out), int'(got_v.sda_out));
					check_field("sda_drive", int'(exp_v.sda_drive), int'(got_v.sda_drive));
					check_field("write_protect", int'(exp_v.wp), int'(got_v.wp));
					check_field("busy", int'(exp_v.busy), int'(got_v.busy));
					check_field("done", int'(exp_v.done), int'(got_v.done));
					check_field("read_byte", int'(exp_v.read_byte), int'(got_v.read_byte));
					check_field("ack_missing", int'(exp_v.ack_missing), int'(got_v.ack_missing));
				end
			end
			if (s_tvalid && s_tready)
				bus_q.push_back(advance_bus(s_tuser, s_tdata[17:0], s_tdata[25:18], s_tdata[26]));
		end
		errors  <= fail_cnt;
		pending <= bus_q.size();
	end

endmodule

// ----- verif/tb_i2c_eeprom_byte_access.sv -----
// Testbench top for the I2C EEPROM byte access: drives requests and config, reports the verdict.
module tb_i2c_eeprom_byte_access;

	localparam int AW         = i2cee_pkg::ADDR_FIELD_W;
	localparam int BW         = i2cee_pkg::BYTE_W;
	localparam int CLK_HI     = 6;
	localparam int CLK_LO     = 6;
	localparam int RST_CYCLES = 7;
	localparam int LIMIT      = 1000000;
	localparam int SETTLE     = 8;

	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic [AW-1:0] BANK_EDGES [8] = '{
		18'h00000, 18'h0FFFF, 18'h10000, 18'h1FFFF,
		18'h20000, 18'h2FFFF, 18'h30000, 18'h3FFFF
	};

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_we    = 1'b0;
	logic                             cfg_index = 1'b0;
	logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                             s_tvalid  = 1'b0;
	logic [i2cee_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic [1:0]                       s_tuser   = i2cee_pkg::MODE_TICK;
	logic                             m_tready  = 1'b0;
	logic                             s_tready;
	logic                             m_tvalid;
	logic [i2cee_pkg::OUT_DATA_W-1:0] m_tdata;

	int                    fails;
	int                    pending;
	int                    src_idle   = 0;
	int                    sink_stall = 0;
	int                    cycles     = 0;
	int                    sent       = 0;
	int                    cur_phase  = i2cee_pkg::PHASE_TICKS_RST;
	int                    cur_wait   = i2cee_pkg::WRITE_WAIT_RST;

	i2c_eeprom_byte_access i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	i2cee_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (fails),
		.pending   (pending)
	);

	always begin
		#(CLK_LO) clk = 1'b1;
		#(CLK_HI) clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_req(input logic [1:0] mode, input logic [AW-1:0] addr,
			input logic [BW-1:0] wd, input logic sda);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'd0, sda, wd, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_cfg(input logic idx, input int val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[i2cee_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == i2cee_pkg::CFG_PHASE_TICKS) cur_phase = val;
		else cur_wait = val;
	endtask

	function automatic logic [AW-1:0] pick_addr();
		if ($urandom_range(3) == 0) return BANK_EDGES[$urandom_range(7)];
		return AW'($urandom_range(18'h3FFFF));
	endfunction

	// Keep SDA low on acks unless sda_hi asks otherwise; noise injects requests while busy.
	task automatic run_access(input logic [1:0] mode, input logic [AW-1:0] addr,
			input logic [BW-1:0] wd, input int sda_hi, input int noise_pct);
		int       ticks;
		int       p;
		logic [1:0] m;
		p     = (cur_phase == 0) ? 1 : cur_phase;
		ticks = (mode == i2cee_pkg::MODE_READ) ? 98 * p : 77 * p + cur_wait + 1;
		send_req(mode, addr, wd, 1'($urandom_range(1)));
		repeat (ticks) begin
			if ($urandom_range(99) < noise_pct) begin
				case ($urandom_range(2))
					0:       m = i2cee_pkg::MODE_WRITE;
					1:       m = i2cee_pkg::MODE_READ;
					default: m = MODE_SPARE;
				endcase
			end else begin
				m = i2cee_pkg::MODE_TICK;
			end
			send_req(m, pick_addr(), BW'($urandom_range(255)), $urandom_range(99) < sda_hi);
		end
	endtask

	task automatic idle_ticks(input int n);
		repeat (n)
			send_req($urandom_range(1) ? i2cee_pkg::MODE_TICK : MODE_SPARE, pick_addr(),
				BW'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic random_phase(input int quota);
		int start;
		int r;
		int sda_hi;
		start = sent;
		while (sent - start < quota) begin
			r = $urandom_range(99);
			case ($urandom_range(3))
				0:       sda_hi = 0;
				1:       sda_hi = 100;
				default: sda_hi = $urandom_range(100);
			endcase
			if (r < 45)
				run_access(i2cee_pkg::MODE_WRITE, pick_addr(), BW'($urandom_range(255)),
					sda_hi, $urandom_range(1) ? 10 : 0);
			else if (r < 90)
				run_access(i2cee_pkg::MODE_READ, pick_addr(), BW'($urandom_range(255)),
					sda_hi, $urandom_range(1) ? 10 : 0);
			else
				idle_ticks($urandom_range(1, 8));
			idle_ticks($urandom_range(0, 3));
		end
	endtask

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bank edges, full and missing acks, busy requests
		set_cfg(i2cee_pkg::CFG_PHASE_TICKS, 1);
		set_cfg(i2cee_pkg::CFG_WRITE_WAIT, 0);
		idle_ticks(3);
		run_access(i2cee_pkg::MODE_WRITE, 18'h00000, 8'h00, 0, 0);
		run_access(i2cee_pkg::MODE_READ, 18'h10000, 8'hFF, 100, 0);
		run_access(i2cee_pkg::MODE_READ, 18'h0FFFF, 8'h5A, 50, 30);
		set_cfg(i2cee_pkg::CFG_PHASE_TICKS, 0);
		set_cfg(i2cee_pkg::CFG_WRITE_WAIT, 5);
		run_access(i2cee_pkg::MODE_WRITE, 18'h2A5A5, 8'h81, 50, 30);

		set_cfg(i2cee_pkg::CFG_PHASE_TICKS, $urandom_range(1, 2));
		set_cfg(i2cee_pkg::CFG_WRITE_WAIT, $urandom_range(0, 12));
		random_phase(50);

		set_cfg(i2cee_pkg::CFG_PHASE_TICKS, 0);
		set_cfg(i2cee_pkg::CFG_WRITE_WAIT, $urandom_range(0, 12));
		src_idle = 87;
		random_phase(50);

		set_cfg(i2cee_pkg::CFG_PHASE_TICKS, 2);
		set_cfg(i2cee_pkg::CFG_WRITE_WAIT, $urandom_range(0, 12));
		src_idle   = 0;
		sink_stall = 87;
		random_phase(50);

		set_cfg(i2cee_pkg::CFG_PHASE_TICKS, 1);
		set_cfg(i2cee_pkg::CFG_WRITE_WAIT, 1);
		src_idle   = 26;
		sink_stall = 26;
		random_phase(25);
		wait_drained();
		random_phase(25);

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
